@@ sv/cpu_tier_governor_assert.svh @@
// Assertion macros for the CPU tier governor.
`ifndef CPU_TIER_GOVERNOR_ASSERT_SVH
`define CPU_TIER_GOVERNOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define CTG_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ctg assertion failed");

// Check cons in the cycle after ante.
`define CTG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ctg assertion failed");

`endif

@@ sv/ctg_pkg.sv @@
// Types, constants and codes shared by the CPU tier governor files.
`default_nettype none
package ctg_pkg;
	localparam int TIME_W  = 40;
	localparam int AMT_W   = 16;
	localparam int OP_W    = 3;
	localparam int TIER_W  = 2;
	localparam int HOLD_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 1;

	localparam int TIER_COUNT = 3;

	typedef logic [TIER_W-1:0] tier_t;
	typedef logic [TIME_W-1:0] time_t;

	localparam tier_t TIER_LIGHT  = TIER_W'(0);
	localparam tier_t TIER_MEDIUM = TIER_W'(1);
	localparam tier_t TIER_TOP    = TIER_W'(TIER_COUNT - 1);

	localparam time_t RECHECK_MS    = TIME_W'(100);
	localparam time_t LAG_HOLD_TIME = TIME_W'(2000);
	localparam logic [AMT_W-1:0] BOOST_FLOOR_MS   = AMT_W'(50);
	localparam logic [AMT_W-1:0] LIGHT_BUDGET_MS  = AMT_W'(16);
	localparam logic [AMT_W-1:0] MEDIUM_BUDGET_MS = AMT_W'(8);
	localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

	localparam logic [OP_W-1:0] OP_TICK    = OP_W'(0);
	localparam logic [OP_W-1:0] OP_BOOST   = OP_W'(1);
	localparam logic [OP_W-1:0] OP_REPORT  = OP_W'(2);
	localparam logic [OP_W-1:0] OP_HOLD    = OP_W'(3);
	localparam logic [OP_W-1:0] OP_RELEASE = OP_W'(4);

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BOOT_DONE = CFG_IDX_W'(1);

	typedef struct packed {
		time_t              now;
		tier_t              cur;
		tier_t              flr;
		time_t              boost_end;
		time_t              floor_end;
		logic [HOLD_W-1:0]  hold;
		logic               armed;
		time_t              due;
		logic               en;
		logic               boot;
	} gov_st_t;

	typedef struct packed {
		tier_t tier;
		logic  tier_changed;
		logic  boost_live;
		logic  lag_live;
	} res_t;
endpackage
`default_nettype wire

@@ sv/ctg_item_if.sv @@
// Input item channel: opcode and amount with valid/ready.
`default_nettype none
interface ctg_item_if
	import ctg_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [AMT_W-1:0]  amount_ms;

	modport source (output valid, output opcode, output amount_ms, input ready);
	modport sink (input valid, input opcode, input amount_ms, output ready);
endinterface
`default_nettype wire

@@ sv/ctg_result_if.sv @@
// Result channel: tier and window status with valid/ready.
`default_nettype none
interface ctg_result_if
	import ctg_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [TIER_W-1:0] tier;
	logic              tier_changed;
	logic              boost_live;
	logic              lag_live;

	modport source (output valid, output tier, output tier_changed, output boost_live,
		output lag_live, input ready);
	modport sink (input valid, input tier, input tier_changed, input boost_live,
		input lag_live, output ready);
endinterface
`default_nettype wire

@@ sv/ctg_cfg_if.sv @@
// Configuration write channel: register index and data with valid/ready.
`default_nettype none
interface ctg_cfg_if
	import ctg_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/cpu_tier_governor.sv @@
// Top level of the three-tier CPU clock governor.
// Latency: a result is valid in the cycle after its input transaction.
// Throughput: one input transaction per cycle while the result register is free or taken.
// Config writes are always ready; item input stalls while one is offered.
// Reset (arst_n low): tier high, all times and counts zero, governor disabled, no result.
`default_nettype none
`include "cpu_tier_governor_assert.svh"
module cpu_tier_governor
	import ctg_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	ctg_item_if.sink   item,
	ctg_result_if.source result,
	ctg_cfg_if.sink    cfg
);

	gov_st_t st_q, st_nx;
	res_t    res_q, res_nx;
	logic    res_valid_q;
	logic    item_acc, cfg_acc;

	function automatic tier_t target(gov_st_t s);
		tier_t t;
		t = TIER_LIGHT;
		if (s.hold != '0) begin
			t = TIER_TOP;
		end else if (s.now < s.boost_end) begin
			t = TIER_MEDIUM;
		end
		if (s.now < s.floor_end && s.flr > t) begin
			t = s.flr;
		end
		return t;
	endfunction

	function automatic gov_st_t arm(gov_st_t s);
		gov_st_t r;
		r = s;
		r.due = (s.boost_end > s.now) ? s.boost_end + RECHECK_MS : s.now + RECHECK_MS;
		r.armed = 1'b1;
		return r;
	endfunction

	function automatic gov_st_t apply_rule(gov_st_t s);
		gov_st_t r;
		tier_t   t;
		r = s;
		t = target(s);
		if (!s.en || !s.boot) begin
			r.cur = TIER_TOP;
			r.armed = 1'b0;
		end else begin
			if (t > r.cur) begin
				r.cur = t;
			end
			if (r.cur > t) begin
				r = arm(r);
			end else if (r.hold == '0 && (r.now < r.boost_end || r.now < r.floor_end)) begin
				r = arm(r);
			end else begin
				r.armed = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic gov_st_t recheck_fire(gov_st_t s);
		gov_st_t r;
		tier_t   t;
		r = s;
		r.armed = 1'b0;
		t = target(s);
		if (s.en && s.boot) begin
			if (r.cur > t) begin
				r.cur = TIER_W'(r.cur - TIER_W'(1));
				if (r.cur > t) begin
					r = arm(r);
				end
			end else if (t > r.cur) begin
				r = apply_rule(r);
			end
		end
		return r;
	endfunction

	function automatic gov_st_t step(gov_st_t s, logic [OP_W-1:0] op, logic [AMT_W-1:0] amt);
		gov_st_t           r;
		logic [AMT_W-1:0]  blen;
		logic [AMT_W-1:0]  budget;
		logic              limited;
		time_t             until_t;
		tier_t             nxt;
		r = s;
		blen = (amt < BOOST_FLOOR_MS) ? BOOST_FLOOR_MS : amt;
		until_t = s.now + TIME_W'(blen);
		budget = LIGHT_BUDGET_MS;
		limited = 1'b1;
		nxt = TIER_W'(s.cur + TIER_W'(1));
		case (op)
			OP_TICK: begin
				r.now = s.now + TIME_W'(1);
				if (r.armed && r.now >= r.due) begin
					r = recheck_fire(r);
				end
			end
			OP_BOOST: begin
				if (s.en) begin
					if (until_t > s.boost_end) begin
						r.boost_end = until_t;
					end
					r = apply_rule(r);
				end
			end
			OP_REPORT: begin
				if (s.en && s.boot) begin
					if (s.cur == TIER_LIGHT) begin
						budget = LIGHT_BUDGET_MS;
					end else if (s.cur == TIER_MEDIUM) begin
						budget = MEDIUM_BUDGET_MS;
					end else begin
						limited = 1'b0;
					end
					if (limited && amt > budget && s.cur < TIER_TOP) begin
						if (s.flr < nxt) begin
							r.flr = nxt;
						end
						r.floor_end = s.now + LAG_HOLD_TIME;
						r = apply_rule(r);
					end
				end
			end
			OP_HOLD: begin
				if (s.en) begin
					if (s.hold == '0) begin
						r.cur = TIER_TOP;
					end
					if (s.hold != HOLD_MAX) begin
						r.hold = HOLD_W'(s.hold + HOLD_W'(1));
					end
				end
			end
			OP_RELEASE: begin
				if (s.en && s.hold != '0) begin
					r.hold = HOLD_W'(s.hold - HOLD_W'(1));
					if (r.hold == '0) begin
						r = apply_rule(r);
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	assign cfg.ready   = 1'b1;
	assign cfg_acc     = cfg.valid && cfg.ready;
	assign item.ready  = (!res_valid_q || result.ready) && !cfg.valid;
	assign item_acc    = item.valid && item.ready;

	always_comb begin
		st_nx = st_q;
		if (cfg_acc) begin
			case (cfg.index)
				CFG_ENABLE: begin
					st_nx.en = cfg.data[0];
					st_nx = apply_rule(st_nx);
				end
				CFG_BOOT_DONE: begin
					st_nx.boot = cfg.data[0];
					st_nx = apply_rule(st_nx);
				end
				default: begin
				end
			endcase
		end else if (item_acc) begin
			st_nx = step(st_q, item.opcode, item.amount_ms);
		end
		res_nx.tier         = st_nx.cur;
		res_nx.tier_changed = st_nx.cur != st_q.cur;
		res_nx.boost_live   = st_nx.now < st_nx.boost_end;
		res_nx.lag_live     = st_nx.now < st_nx.floor_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.now       <= '0;
			st_q.cur       <= TIER_TOP;
			st_q.flr       <= TIER_LIGHT;
			st_q.boost_end <= '0;
			st_q.floor_end <= '0;
			st_q.hold      <= '0;
			st_q.armed     <= 1'b0;
			st_q.due       <= '0;
			st_q.en        <= 1'b0;
			st_q.boot      <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (item_acc) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			res_q <= res_nx;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.tier         = res_q.tier;
	assign result.tier_changed = res_q.tier_changed;
	assign result.boost_live   = res_q.boost_live;
	assign result.lag_live     = res_q.lag_live;

	`CTG_ASSERT_SAME(a_forced_top, (!st_q.en || !st_q.boot), (st_q.cur == TIER_TOP))
	`CTG_ASSERT_SAME(a_disarmed_off, (!st_q.en || !st_q.boot), (!st_q.armed))
	`CTG_ASSERT_SAME(a_hold_top, (st_q.hold != '0), (st_q.cur == TIER_TOP))
	`CTG_ASSERT_NEXT(a_result_follows, item_acc, (res_valid_q && res_q.tier == st_q.cur))

endmodule
`default_nettype wire
